// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QMJ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QMJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qmj_pkg.sv
`timescale 1ns / 1ps
package qmj_pkg;

  localparam int T_W    = 16;
  localparam int UFRAC  = 30;
  localparam int U_W    = UFRAC + 1;
  localparam int UDIV_W = T_W + UFRAC;
  localparam int EL_W   = 24;
  localparam int VAL_W  = 32;
  localparam int TAG_W  = 32;
  localparam int AX_W   = 2;
  localparam int DLT_W  = VAL_W + 1;
  localparam int POLY_W = 40;
  localparam int PMAG_W = POLY_W - 1;
  localparam int PROD_W = DLT_W + PMAG_W;
  localparam int SC_W   = PROD_W + 40;
  localparam int DV_W   = SC_W - UFRAC;
  localparam int RES_W  = 48;
  localparam int NTERM  = 5;

  localparam logic [AX_W-1:0] AXIS_YAW  = 2'd3;
  localparam logic [T_W-1:0]  DUR_RESET = 16'd1000;

  typedef struct packed {
    logic [AX_W-1:0]          axis;
    logic [TAG_W-1:0]         tag;
    logic signed [VAL_W-1:0]  start;
    logic signed [DLT_W-1:0]  delta;
    logic [T_W-1:0]           tms;
    logic                     mid_seg;
  } qmj_side_t;

  typedef logic [NTERM-1:0][POLY_W-1:0] qmj_poly_t;

endpackage

// File: rtl/qmj_div_pipe.sv
`timescale 1ns / 1ps
module qmj_div_pipe #(
  parameter int W  = 46,
  parameter int PW = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [W-1:0]             in_num,
  input  logic [qmj_pkg::T_W-1:0]  in_den,
  input  logic [PW-1:0]            in_pay,
  output logic                     out_valid,
  output logic [W-1:0]             out_quot,
  output logic [PW-1:0]            out_pay
);
  import qmj_pkg::*;

  localparam int BPS = 8;
  localparam int ST  = (W + BPS - 1) / BPS;

  logic           vld_q [1:ST];
  logic [W-1:0]   num_q [1:ST];
  logic [T_W-1:0] rem_q [1:ST];
  logic [T_W-1:0] den_q [1:ST];
  logic [PW-1:0]  pay_q [1:ST];

  genvar s;
  generate
    for (s = 0; s < ST; s++) begin : g_st
      logic           src_vld;
      logic [W-1:0]   src_num;
      logic [T_W-1:0] src_rem;
      logic [T_W-1:0] src_den;
      logic [PW-1:0]  src_pay;
      logic [W-1:0]   nxt_num;
      logic [T_W-1:0] nxt_rem;

      if (s == 0) begin : g_in
        assign src_vld = in_valid;
        assign src_num = in_num;
        assign src_rem = '0;
        assign src_den = in_den;
        assign src_pay = in_pay;
      end else begin : g_mid
        assign src_vld = vld_q[s];
        assign src_num = num_q[s];
        assign src_rem = rem_q[s];
        assign src_den = den_q[s];
        assign src_pay = pay_q[s];
      end

      // restoring steps: shift one dividend bit into the remainder, subtract if it fits
      always_comb begin
        logic [T_W:0] r;
        logic [W-1:0] w;
        r = {1'b0, src_rem};
        w = src_num;
        for (int k = 0; k < BPS; k++) begin
          if (s * BPS + k < W) begin
            r = {r[T_W-1:0], w[W-1]};
            w = {w[W-2:0], 1'b0};
            if (r >= {1'b0, src_den}) begin
              r    = r - {1'b0, src_den};
              w[0] = 1'b1;
            end
          end
        end
        nxt_num = w;
        nxt_rem = r[T_W-1:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[s+1] <= 1'b0;
        end else if (en) begin
          vld_q[s+1] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          num_q[s+1] <= nxt_num;
          rem_q[s+1] <= nxt_rem;
          den_q[s+1] <= src_den;
          pay_q[s+1] <= src_pay;
        end
      end
    end
  endgenerate

  assign out_valid = vld_q[ST];
  assign out_quot  = num_q[ST];
  assign out_pay   = pay_q[ST];

endmodule

// File: rtl/qmj_poly.sv
`timescale 1ns / 1ps
module qmj_poly (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qmj_pkg::U_W-1:0]   in_u,
  input  qmj_pkg::qmj_side_t        in_side,
  output logic                      out_valid,
  output qmj_pkg::qmj_poly_t        out_poly,
  output qmj_pkg::qmj_side_t        out_side
);
  import qmj_pkg::*;

  localparam int PX_W = POLY_W + 2;
  localparam logic signed [PX_W-1:0] K60  = 42'sd64424509440;
  localparam logic signed [PX_W-1:0] K360 = 42'sd386547056640;

  function automatic logic [U_W-1:0] qmul(input logic [U_W-1:0] a, input logic [U_W-1:0] b);
    logic [2*U_W-1:0] m;
    m = a * b;
    return m[UFRAC +: U_W];
  endfunction

  function automatic logic signed [PX_W-1:0] ext(input logic [U_W-1:0] a);
    return $signed({{(PX_W-U_W){1'b0}}, a});
  endfunction

  logic           v1, v2, v3, v4;
  qmj_side_t      sd1, sd2, sd3, sd4;
  logic [U_W-1:0] u1, u2, u3, u4;
  logic [U_W-1:0] pa1, pa2, pa3, pa4;
  logic [U_W-1:0] pb2, pb3, pb4;
  logic [U_W-1:0] pc3, pc4;
  logic [U_W-1:0] pd4;

  logic signed [PX_W-1:0] e1, e2, e3, e4, e5;
  logic signed [PX_W-1:0] q0, q1, q2, q3, q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  // one power per stage: u^2, u^3, u^4, u^5
  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= in_side;
      u1  <= in_u;
      pa1 <= qmul(in_u, in_u);
      sd2 <= sd1;
      u2  <= u1;
      pa2 <= pa1;
      pb2 <= qmul(pa1, u1);
      sd3 <= sd2;
      u3  <= u2;
      pa3 <= pa2;
      pb3 <= pb2;
      pc3 <= qmul(pb2, u2);
      sd4 <= sd3;
      u4  <= u3;
      pa4 <= pa3;
      pb4 <= pb3;
      pc4 <= pc3;
      pd4 <= qmul(pc3, u3);
      out_side <= sd4;
      out_poly[0] <= q0[POLY_W-1:0];
      out_poly[1] <= q1[POLY_W-1:0];
      out_poly[2] <= q2[POLY_W-1:0];
      out_poly[3] <= q3[POLY_W-1:0];
      out_poly[4] <= q4[POLY_W-1:0];
    end
  end

  always_comb begin
    e1 = ext(u4);
    e2 = ext(pa4);
    e3 = ext(pb4);
    e4 = ext(pc4);
    e5 = ext(pd4);
    q0 = 42'sd10 * e3 - 42'sd15 * e4 + 42'sd6 * e5;
    q1 = 42'sd30 * e2 - 42'sd60 * e3 + 42'sd30 * e4;
    q2 = 42'sd60 * e1 - 42'sd180 * e2 + 42'sd120 * e3;
    q3 = K60 - 42'sd360 * e1 + 42'sd360 * e2;
    q4 = 42'sd720 * e1 - K360;
  end

endmodule

// File: rtl/qmj_scale_lane.sv
`timescale 1ns / 1ps
module qmj_scale_lane #(
  parameter int ORDER = 0,
  parameter int PW    = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qmj_pkg::DLT_W-1:0]  delta,
  input  logic signed [qmj_pkg::POLY_W-1:0] poly,
  input  logic [qmj_pkg::T_W-1:0]           tms,
  input  logic [PW-1:0]                     in_pay,
  output logic                              out_valid,
  output logic signed [qmj_pkg::RES_W-1:0]  result,
  output logic [PW-1:0]                     out_pay
);
  import qmj_pkg::*;

  localparam int NMUL = 4;
  localparam int PLO  = 20;
  localparam int LPW  = 1 + T_W + PW;

  logic [DLT_W-1:0]  dabs;
  logic [POLY_W-1:0] pabs;

  logic                     v1, v2, v3;
  logic [LPW-1:0]           sd1, sd2, sd3;
  logic [DLT_W-1:0]         dmag1;
  logic [PMAG_W-1:0]        pmag1;
  logic [DLT_W+PLO-1:0]     pplo;
  logic [DLT_W+PMAG_W-PLO-1:0] pphi;
  logic [PROD_W-1:0]        prod_q;

  assign dabs = delta[DLT_W-1] ? DLT_W'(-delta) : DLT_W'(delta);
  assign pabs = poly[POLY_W-1] ? POLY_W'(-poly) : POLY_W'(poly);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // magnitudes, split product, then merge
  always_ff @(posedge clk) begin
    if (en) begin
      sd1    <= {delta[DLT_W-1] ^ poly[POLY_W-1], tms, in_pay};
      dmag1  <= dabs;
      pmag1  <= pabs[PMAG_W-1:0];
      sd2    <= sd1;
      pplo   <= dmag1 * pmag1[PLO-1:0];
      pphi   <= dmag1 * pmag1[PMAG_W-1:PLO];
      sd3    <= sd2;
      prod_q <= PROD_W'(pplo) + {pphi, {PLO{1'b0}}};
    end
  end

  logic [SC_W-1:0] mx_q [1:NMUL];
  logic [LPW-1:0]  ms_q [1:NMUL];
  logic            mv_q [1:NMUL];

  genvar k;
  generate
    for (k = 0; k < NMUL; k++) begin : g_mul
      logic [SC_W-1:0] src_x;
      logic [LPW-1:0]  src_s;
      logic            src_v;
      logic [SC_W-1:0] nxt_x;

      if (k == 0) begin : g_in
        assign src_x = SC_W'(prod_q);
        assign src_s = sd3;
        assign src_v = v3;
      end else begin : g_mid
        assign src_x = mx_q[k];
        assign src_s = ms_q[k];
        assign src_v = mv_q[k];
      end

      // times 1000 as 1024 - 16 - 8
      assign nxt_x = (k < ORDER) ? (src_x << 10) - (src_x << 4) - (src_x << 3) : src_x;

      always_ff @(posedge clk) begin
        if (rst) begin
          mv_q[k+1] <= 1'b0;
        end else if (en) begin
          mv_q[k+1] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          mx_q[k+1] <= nxt_x;
          ms_q[k+1] <= src_s;
        end
      end
    end
  endgenerate

  wire [DV_W-1:0] dq  [NMUL+1];
  wire [LPW-1:0]  dp  [NMUL+1];
  wire            dvv [NMUL+1];

  assign dq[0]  = mx_q[NMUL][SC_W-1:UFRAC];
  assign dp[0]  = ms_q[NMUL];
  assign dvv[0] = mv_q[NMUL];

  generate
    for (k = 0; k < NMUL; k++) begin : g_div
      qmj_div_pipe #(
        .W  (DV_W),
        .PW (LPW)
      ) u_div (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (dvv[k]),
        .in_num    (dq[k]),
        .in_den    ((k < ORDER) ? dp[k][PW +: T_W] : T_W'(1)),
        .in_pay    (dp[k]),
        .out_valid (dvv[k+1]),
        .out_quot  (dq[k+1]),
        .out_pay   (dp[k+1])
      );
    end
  endgenerate

  logic                    fneg, fsat;
  logic [RES_W-1:0]        fmag;
  logic signed [RES_W-1:0] result_next;

  always_comb begin
    fneg = dp[NMUL][LPW-1];
    fsat = |dq[NMUL][DV_W-1:RES_W-1];
    fmag = dq[NMUL][RES_W-1:0];
    if (fsat) begin
      result_next = fneg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      result_next = fneg ? RES_W'(-fmag) : fmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvv[NMUL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result  <= result_next;
      out_pay <= dp[NMUL][PW-1:0];
    end
  end

endmodule

// File: rtl/quintic_min_jerk_reference.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Minimum-jerk quintic reference, one axis sample per transfer. Each input
// transfer carries an axis, the elapsed time in ms, and the segment's start and
// end values in signed fixed point; the result carries position and the first
// four time derivatives per second^n, with jerk and snap held at zero for yaw
// and all derivatives at zero at or beyond the segment ends. The block takes
// one transfer per clock while the output side does not stall; the pipeline
// depth comes from the restoring dividers, eight quotient bits per stage,
// that form normalized time and divide each derivative by the duration once
// per order. A stall on the output holds the whole pipeline. The duration
// register is written through its own channel, which is always ready; a
// value of zero acts as one millisecond.
module quintic_min_jerk_reference (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qmj_pkg::T_W-1:0]             cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [qmj_pkg::AX_W-1:0]            axis_select,
  input  logic signed [qmj_pkg::EL_W-1:0]     elapsed_ms,
  input  logic signed [qmj_pkg::VAL_W-1:0]    start_value,
  input  logic signed [qmj_pkg::VAL_W-1:0]    end_value,
  input  logic [qmj_pkg::TAG_W-1:0]           time_tag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qmj_pkg::AX_W-1:0]            axis_echo,
  output logic signed [qmj_pkg::VAL_W-1:0]    ref_position,
  output logic signed [qmj_pkg::RES_W-1:0]    ref_velocity,
  output logic signed [qmj_pkg::RES_W-1:0]    ref_acceleration,
  output logic signed [qmj_pkg::RES_W-1:0]    ref_jerk,
  output logic signed [qmj_pkg::RES_W-1:0]    ref_snap,
  output logic [qmj_pkg::TAG_W-1:0]           time_tag_out
);
  import qmj_pkg::*;

  localparam int SIDE_W = $bits(qmj_side_t);
  localparam int POS_W  = RES_W + 1;

  // Duration register.
  logic [T_W-1:0] segment_duration_ms;
  logic [T_W-1:0] tms_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_duration_ms <= DUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      segment_duration_ms <= cfg_data;
    end
  end

  assign tms_eff = (segment_duration_ms == '0) ? T_W'(1) : segment_duration_ms;

  // The whole pipeline advances together; an occupied, untaken output holds it.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input stage: clamp elapsed time, form delta and the mid-segment flag.
  logic signed [EL_W-1:0] tms_s;
  logic [T_W-1:0]         t_clamp;
  qmj_side_t              in_side;
  logic                   sa_vld;
  logic [T_W-1:0]         sa_t;
  qmj_side_t              sa_side;

  always_comb begin
    tms_s = $signed({{(EL_W-T_W){1'b0}}, tms_eff});
    if (elapsed_ms < 0) begin
      t_clamp = '0;
    end else if (elapsed_ms > tms_s) begin
      t_clamp = tms_eff;
    end else begin
      t_clamp = elapsed_ms[T_W-1:0];
    end
    in_side.axis    = axis_select;
    in_side.tag     = time_tag;
    in_side.start   = start_value;
    in_side.delta   = DLT_W'($signed({end_value[VAL_W-1], end_value})
                      - $signed({start_value[VAL_W-1], start_value}));
    in_side.tms     = tms_eff;
    in_side.mid_seg = (elapsed_ms > 0) && (elapsed_ms < tms_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else if (en) begin
      sa_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_t    <= t_clamp;
      sa_side <= in_side;
    end
  end

  // Normalized time u = t * 2^30 / T.
  logic              ud_vld;
  logic [UDIV_W-1:0] ud_quot;
  logic [SIDE_W-1:0] ud_pay;

  qmj_div_pipe #(
    .W  (UDIV_W),
    .PW (SIDE_W)
  ) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sa_vld),
    .in_num    ({sa_t, {UFRAC{1'b0}}}),
    .in_den    (sa_side.tms),
    .in_pay    (sa_side),
    .out_valid (ud_vld),
    .out_quot  (ud_quot),
    .out_pay   (ud_pay)
  );

  // Powers of u and the five basis polynomials.
  logic      pl_vld;
  qmj_poly_t pl_poly;
  qmj_side_t pl_side;

  qmj_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ud_vld),
    .in_u      (ud_quot[U_W-1:0]),
    .in_side   (qmj_side_t'(ud_pay)),
    .out_valid (pl_vld),
    .out_poly  (pl_poly),
    .out_side  (pl_side)
  );

  // One lane per derivative order; lane 0 carries the sideband, the others a zero flag.
  wire [NTERM-1:0]         lane_vld;
  wire [NTERM-1:1]         lane_zero;
  logic signed [RES_W-1:0] lane_res [NTERM];
  logic [SIDE_W-1:0]       lane_side;
  qmj_side_t               side_f;

  genvar j;
  generate
    for (j = 0; j < NTERM; j++) begin : g_lane
      if (j == 0) begin : g_pos
        qmj_scale_lane #(
          .ORDER (j),
          .PW    (SIDE_W)
        ) u_lane (
          .clk       (clk),
          .rst       (rst),
          .en        (en),
          .in_valid  (pl_vld),
          .delta     (pl_side.delta),
          .poly      ($signed(pl_poly[j])),
          .tms       (pl_side.tms),
          .in_pay    (pl_side),
          .out_valid (lane_vld[j]),
          .result    (lane_res[j]),
          .out_pay   (lane_side)
        );
      end else begin : g_der
        logic zf;
        assign zf = !pl_side.mid_seg || ((j >= 3) && (pl_side.axis == AXIS_YAW));
        qmj_scale_lane #(
          .ORDER (j),
          .PW    (1)
        ) u_lane (
          .clk       (clk),
          .rst       (rst),
          .en        (en),
          .in_valid  (pl_vld),
          .delta     (pl_side.delta),
          .poly      ($signed(pl_poly[j])),
          .tms       (pl_side.tms),
          .in_pay    (zf),
          .out_valid (lane_vld[j]),
          .result    (lane_res[j]),
          .out_pay   (lane_zero[j])
        );
      end
    end
  endgenerate

  assign side_f = qmj_side_t'(lane_side);

  // Output stage: add start, saturate position, zero derivatives outside the segment and yaw jerk/snap.
  logic signed [POS_W-1:0] pos_sum;
  logic signed [VAL_W-1:0] pos_next;

  always_comb begin
    pos_sum = $signed({{(POS_W-VAL_W){side_f.start[VAL_W-1]}}, side_f.start})
            + $signed({lane_res[0][RES_W-1], lane_res[0]});
    if (pos_sum[POS_W-1:VAL_W-1] != '0 && pos_sum[POS_W-1:VAL_W-1] != '1) begin
      pos_next = pos_sum[POS_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      pos_next = pos_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lane_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis_echo        <= side_f.axis;
      time_tag_out     <= side_f.tag;
      ref_position     <= pos_next;
      ref_velocity     <= lane_zero[1] ? '0 : lane_res[1];
      ref_acceleration <= lane_zero[2] ? '0 : lane_res[2];
      ref_jerk         <= lane_zero[3] ? '0 : lane_res[3];
      ref_snap         <= lane_zero[4] ? '0 : lane_res[4];
    end
  end

  `QMJ_ASSERT_SAME(a_lane_sync, 1'b1, lane_vld == {NTERM{lane_vld[0]}}, "derivative lanes out of step")
  `QMJ_ASSERT_SAME(a_u_range, ud_vld, ud_quot[UDIV_W-1:UFRAC+1] == '0 && (!ud_quot[UFRAC] || ud_quot[UFRAC-1:0] == '0), "normalized time above one")
  `QMJ_ASSERT_SAME(a_yaw_zero, out_valid && axis_echo == AXIS_YAW, ref_jerk == '0 && ref_snap == '0, "yaw result carries jerk or snap")
  `QMJ_ASSERT_NEXT(a_stage_hold, sa_vld && !en, sa_vld, "input stage dropped a held item")

endmodule
